[hw/rtl/text_console_writer_assert.svh]
// Assertion macros shared by the text console writer checkers.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tcw_pkg.sv]
// Shared types and constants of the text console writer.
// Used by the cell memory, the top level and the checker; no dependencies.
package tcw_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;

  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 1;

  localparam int TAB_STOP = 8;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_SET   = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_EXEC   = 6'b000100,
    ST_BLANK  = 6'b001000,
    ST_RDWAIT = 6'b010000,
    ST_RESP   = 6'b100000
  } state_e;

endpackage

[hw/rtl/tcw_cell_mem.sv]
// Cell buffer storage: one write port, one read port, registered read data.
// Depends on tcw_pkg for the cell width.
module tcw_cell_mem #(
  parameter int DEPTH = tcw_pkg::COLS_DEF * tcw_pkg::ROWS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [tcw_pkg::CELL_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [tcw_pkg::CELL_W-1:0] rdata_o
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem_q [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/text_console_writer.sv]
// Text console writer: a COLS x ROWS buffer of 16-bit cells plus a cursor.
// Uses tcw_pkg and the tcw_cell_mem storage.
//
// Usage:
//  - Requests enter on the s_axis channel: tuser carries the request kind
//    (put character, read cell, set cursor, clear screen), tdata the character,
//    colors and the position for read and set. Each request yields exactly one
//    response transaction on m_axis with the cursor after the request, the cell
//    read (zero for other kinds) and a position error flag in tuser.
//  - One request at a time. A request goes from IDLE to EXEC, then RDWAIT for a
//    read, BLANK for a scroll or CLEAR for a clear, and RESP to the output register.
//  - A tab writes one space per cycle until the next tab stop.
//  - Scrolling moves a row offset instead of copying; the freed row is blanked
//    at one cell per cycle.
//  - Clear screen walks the whole buffer, one cell per cycle.
//  - After reset the same walk zeroes the buffer; s_axis_tready stays low
//    until the walk completes.
//  - A response waiting on a stalled m_axis sits in the output register; the
//    next request is accepted meanwhile and waits only when its own response
//    is ready.
module text_console_writer #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [7:0] char_code, [11:8] fg_color, [15:12] bg_color, [22:16] col, [27:23] row
  input  logic [tcw_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [tcw_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [6:0] cursor_col, [11:7] cursor_row, [27:12] cell_data
  output logic [tcw_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [0] pos_error
  output logic [tcw_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import tcw_pkg::*;

  localparam int NCELLS = COLS * ROWS;
  localparam int AW     = $clog2(NCELLS);
  localparam logic [COL_W-1:0] TAB_MASK = COL_W'(TAB_STOP - 1);
  localparam logic [COL_W-1:0] COLS_C   = COL_W'(COLS);
  localparam logic [ROW_W-1:0] ROWS_C   = ROW_W'(ROWS);
  localparam logic [ROW_W:0]   ROWS_W   = (ROW_W+1)'(ROWS);

  state_e state_q, state_d;

  // request fields
  req_e             req_q;
  logic [7:0]       ch_q;
  logic [3:0]       fg_q, bg_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;

  logic [COL_W-1:0] cur_x_q, cur_x_d;
  logic [ROW_W-1:0] cur_y_q, cur_y_d;
  logic [ROW_W-1:0] base_q, base_d;          // physical row of logical row 0
  logic [ROW_W-1:0] blank_row_q, blank_row_d;
  logic [COL_W-1:0] blank_col_q, blank_col_d;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  logic             clr_resp_q, clr_resp_d;

  logic [CELL_W-1:0] res_data_q, res_data_d;
  logic              res_err_q, res_err_d;

  logic                 m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;
  logic [M_TUSER_W-1:0] m_user_q, m_user_d;

  // memory port signals
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, addr_calc;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  logic [ROW_W-1:0] lrow, prow;
  logic [COL_W-1:0] acol;
  logic [ROW_W:0]   psum;
  logic             accept, oob, is_put_cell, resp_load;
  logic [COL_W-1:0] nx;
  logic [ROW_W-1:0] ny;
  logic [7:0]       ch_eff;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign oob = (col_q >= COLS_C) || (row_q >= ROWS_C);
  assign is_put_cell = (ch_q != CH_NUL) && (ch_q != CH_CR) && (ch_q != CH_LF);
  assign ch_eff = (ch_q == CH_TAB) ? CH_SPACE : ch_q;
  assign nx = cur_x_q + COL_W'(1);
  assign ny = cur_y_q + ROW_W'(1);

  // logical row to physical row through the scroll offset
  always_comb begin
    lrow = (req_q == REQ_READ) ? row_q : cur_y_q;
    acol = (state_q == ST_BLANK) ? blank_col_q
         : ((req_q == REQ_READ) ? col_q : cur_x_q);
    psum = {1'b0, lrow} + {1'b0, base_q};
    if (psum >= ROWS_W) begin
      psum = psum - ROWS_W;
    end
    prow = (state_q == ST_BLANK) ? blank_row_q : psum[ROW_W-1:0];
    addr_calc = AW'(prow * COLS) + AW'(acol);
  end

  assign resp_load = (state_q == ST_RESP) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d     = state_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    base_d      = base_q;
    blank_row_d = blank_row_q;
    blank_col_d = blank_col_q;
    clr_addr_d  = clr_addr_q;
    clr_resp_d  = clr_resp_q;
    res_data_d  = res_data_q;
    res_err_d   = res_err_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = addr_calc;
    mem_wdata   = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        if (clr_addr_q == AW'(NCELLS - 1)) begin
          clr_addr_d = '0;
          state_d    = clr_resp_q ? ST_RESP : ST_IDLE;
          clr_resp_d = 1'b0;
        end else begin
          clr_addr_d = clr_addr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_data_d = '0;
        res_err_d  = 1'b0;
        state_d    = ST_RESP;
        unique case (req_q)
          REQ_PUT: begin
            priority if (is_put_cell) begin
              mem_we    = 1'b1;
              mem_wdata = {bg_q, fg_q, ch_eff};
              if (nx == COLS_C) begin
                cur_x_d = '0;
                if (ny == ROWS_C) begin
                  // wrapped off the last row: scroll, blank the old top row
                  base_d      = (base_q == ROWS_C - ROW_W'(1)) ? '0 : base_q + ROW_W'(1);
                  blank_row_d = base_q;
                  blank_col_d = '0;
                  cur_y_d     = ROWS_C - ROW_W'(1);
                  state_d     = ST_BLANK;
                end else begin
                  cur_y_d = ny;
                end
              end else begin
                cur_x_d = nx;
                if ((ch_q == CH_TAB) && ((nx & TAB_MASK) != '0)) begin
                  state_d = ST_EXEC;
                end
              end
            end else if (ch_q == CH_CR) begin
              cur_x_d = '0;
            end else if (ch_q == CH_LF) begin
              if (ny == ROWS_C) begin
                base_d      = (base_q == ROWS_C - ROW_W'(1)) ? '0 : base_q + ROW_W'(1);
                blank_row_d = base_q;
                blank_col_d = '0;
                cur_x_d     = '0;
                cur_y_d     = ROWS_C - ROW_W'(1);
                state_d     = ST_BLANK;
              end else begin
                cur_y_d = ny;
              end
            end else begin
              state_d = ST_RESP;
            end
          end
          REQ_READ: begin
            res_err_d = oob;
            if (!oob) begin
              mem_re  = 1'b1;
              state_d = ST_RDWAIT;
            end
          end
          REQ_SET: begin
            res_err_d = oob;
            if (!oob) begin
              cur_x_d = col_q;
              cur_y_d = row_q;
            end
          end
          REQ_CLEAR: begin
            cur_x_d    = '0;
            cur_y_d    = '0;
            base_d     = '0;
            clr_addr_d = '0;
            clr_resp_d = 1'b1;
            state_d    = ST_CLEAR;
          end
          default: ;
        endcase
      end
      ST_BLANK: begin
        mem_we = 1'b1;
        if (blank_col_q == COLS_C - COL_W'(1)) begin
          state_d = ST_RESP;
        end else begin
          blank_col_d = blank_col_q + COL_W'(1);
        end
      end
      ST_RDWAIT: begin
        res_data_d = mem_rdata;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        if (resp_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    if (resp_load) begin
      m_valid_d = 1'b1;
      m_data_d  = M_TDATA_W'({res_data_q, cur_y_q, cur_x_q});
      m_user_d  = M_TUSER_W'(res_err_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      base_q     <= '0;
      clr_addr_q <= '0;
      clr_resp_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_x_q    <= cur_x_d;
      cur_y_q    <= cur_y_d;
      base_q     <= base_d;
      clr_addr_q <= clr_addr_d;
      clr_resp_q <= clr_resp_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_e'(s_axis_tuser[1:0]);
      ch_q  <= s_axis_tdata[7:0];
      fg_q  <= s_axis_tdata[11:8];
      bg_q  <= s_axis_tdata[15:12];
      col_q <= s_axis_tdata[22:16];
      row_q <= s_axis_tdata[27:23];
    end
    blank_row_q <= blank_row_d;
    blank_col_q <= blank_col_d;
    res_data_q  <= res_data_d;
    res_err_q   <= res_err_d;
    m_data_q    <= m_data_d;
    m_user_q    <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  tcw_cell_mem #(
    .DEPTH (NCELLS),
    .AW    (AW)
  ) u_cell_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (addr_calc),
    .rdata_o (mem_rdata)
  );

endmodule

[hw/rtl/tcw_checker.sv]
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_assert.svh.
`include "text_console_writer_assert.svh"

module tcw_checker #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  // [6:0] cursor_col, [11:7] cursor_row, [27:12] cell_data
  input logic [tcw_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [0] pos_error
  input logic [tcw_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import tcw_pkg::*;

  localparam logic [COL_W-1:0] COLS_C = COL_W'(COLS);
  localparam logic [ROW_W-1:0] ROWS_C = ROW_W'(ROWS);

  `TCW_ASSERT_NXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "response changed under stall")
  `TCW_ASSERT_NOW(a_col_range, m_axis_tvalid, m_axis_tdata[6:0] < COLS_C, "cursor column out of range")
  `TCW_ASSERT_NOW(a_row_range, m_axis_tvalid, m_axis_tdata[11:7] < ROWS_C, "cursor row out of range")
  `TCW_ASSERT_NOW(a_err_no_data, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[27:12] == '0, "cell data with position error")
  `TCW_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken while busy")

endmodule

bind text_console_writer tcw_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_tcw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
